@@ hdl/iea_pkg.sv @@
// Shared types and constants for the indexed effective address unit.
// Used by iea_decode, iea_addr and indexed_effective_address_unit.
package iea_pkg;

  localparam int unsigned AddrWidth = 16;

  // Mode codes in bits 3..0 of an indexed postbyte
  localparam logic [3:0] ModeInc1    = 4'h0;
  localparam logic [3:0] ModeInc2    = 4'h1;
  localparam logic [3:0] ModeDec1    = 4'h2;
  localparam logic [3:0] ModeDec2    = 4'h3;
  localparam logic [3:0] ModeZero    = 4'h4;
  localparam logic [3:0] ModeAccB    = 4'h5;
  localparam logic [3:0] ModeAccA    = 4'h6;
  localparam logic [3:0] ModeOff8    = 4'h8;
  localparam logic [3:0] ModeOff16   = 4'h9;
  localparam logic [3:0] ModeAccD    = 4'hB;
  localparam logic [3:0] ModePcOff8  = 4'hC;
  localparam logic [3:0] ModePcOff16 = 4'hD;
  localparam logic [3:0] ModeExtInd  = 4'hF;

  localparam logic [7:0] PostExtInd  = 8'h9F;

  localparam logic [2:0] DeltaNone    = 3'd0;
  localparam logic [2:0] DeltaOne     = 3'd1;
  localparam logic [2:0] DeltaTwo     = 3'd2;
  localparam logic [2:0] DeltaInvalid = 3'b111;

  localparam logic [2:0] BiasZero   = 3'd0;
  localparam logic [2:0] BiasPlus1  = 3'd1;
  localparam logic [2:0] BiasPlus2  = 3'd2;
  localparam logic [2:0] BiasMinus1 = 3'b111;
  localparam logic [2:0] BiasMinus2 = 3'b110;

  typedef enum logic [1:0] {
    BASE_REG,
    BASE_PC,
    BASE_ZERO
  } base_sel_t;

  typedef enum logic [2:0] {
    OFF_ZERO,
    OFF_SEXT5,
    OFF_ACC_B,
    OFF_ACC_A,
    OFF_EXT8,
    OFF_EXT16,
    OFF_ACC_D
  } off_sel_t;

  typedef struct packed {
    base_sel_t  base_sel;
    off_sel_t   off_sel;
    logic [1:0] reg_sel;
    logic [4:0] off5;
    logic [2:0] bias;     // small signed constant added to the sum
    logic       ea_base;  // post-increment: address is the unstepped register
    logic       wr;
    logic       ind;
    logic [2:0] delta;
    logic       bad;
  } iea_ctrl_t;

  typedef struct packed {
    logic [AddrWidth-1:0] ea_address;
    logic                 needs_indirect;
    logic                 index_write;
    logic [1:0]           index_select;
    logic [AddrWidth-1:0] index_new;
    logic [2:0]           pc_delta;
    logic                 invalid_post;
  } iea_result_t;

endpackage

@@ hdl/iea_decode.sv @@
// Postbyte decoder: turns the mode byte into adder controls and flags.
// Depends on iea_pkg.
module iea_decode
  import iea_pkg::*;
(
  input  logic [7:0] postbyte,
  output iea_ctrl_t  ctrl
);

  always_comb begin
    ctrl          = '0;
    ctrl.base_sel = BASE_REG;
    ctrl.off_sel  = OFF_ZERO;
    ctrl.reg_sel  = postbyte[6:5];
    ctrl.off5     = postbyte[4:0];
    ctrl.bias     = BiasZero;
    ctrl.delta    = DeltaNone;
    if (!postbyte[7]) begin
      ctrl.off_sel = OFF_SEXT5;
    end else begin
      ctrl.ind = postbyte[4];
      unique case (postbyte[3:0])
        ModeInc1: begin
          ctrl.bias    = BiasPlus1;
          ctrl.ea_base = 1'b1;
          ctrl.wr      = 1'b1;
          ctrl.bad     = postbyte[4];
        end
        ModeInc2: begin
          ctrl.bias    = BiasPlus2;
          ctrl.ea_base = 1'b1;
          ctrl.wr      = 1'b1;
        end
        ModeDec1: begin
          ctrl.bias = BiasMinus1;
          ctrl.wr   = 1'b1;
          ctrl.bad  = postbyte[4];
        end
        ModeDec2: begin
          ctrl.bias = BiasMinus2;
          ctrl.wr   = 1'b1;
        end
        ModeZero: ctrl.off_sel = OFF_ZERO;
        ModeAccB: ctrl.off_sel = OFF_ACC_B;
        ModeAccA: ctrl.off_sel = OFF_ACC_A;
        ModeOff8: begin
          ctrl.off_sel = OFF_EXT8;
          ctrl.delta   = DeltaOne;
        end
        ModeOff16: begin
          ctrl.off_sel = OFF_EXT16;
          ctrl.delta   = DeltaTwo;
        end
        ModeAccD: ctrl.off_sel = OFF_ACC_D;
        ModePcOff8: begin
          // PC-relative uses the PC past the offset bytes
          ctrl.base_sel = BASE_PC;
          ctrl.off_sel  = OFF_EXT8;
          ctrl.bias     = BiasPlus1;
          ctrl.delta    = DeltaOne;
        end
        ModePcOff16: begin
          ctrl.base_sel = BASE_PC;
          ctrl.off_sel  = OFF_EXT16;
          ctrl.bias     = BiasPlus2;
          ctrl.delta    = DeltaTwo;
        end
        ModeExtInd: begin
          ctrl.base_sel = BASE_ZERO;
          ctrl.off_sel  = OFF_EXT16;
          ctrl.delta    = DeltaTwo;
          ctrl.bad      = (postbyte != PostExtInd);
        end
        default: ctrl.bad = 1'b1;
      endcase
    end
  end

endmodule

@@ hdl/iea_addr.sv @@
// Address datapath: register select, offset extension and the 16-bit sum.
// Depends on iea_pkg; driven by the iea_decode controls.
module iea_addr
  import iea_pkg::*;
(
  input  iea_ctrl_t              ctrl,
  input  logic [AddrWidth-1:0]   reg_x,
  input  logic [AddrWidth-1:0]   reg_y,
  input  logic [AddrWidth-1:0]   reg_u,
  input  logic [AddrWidth-1:0]   reg_s,
  input  logic [AddrWidth-1:0]   acc_d,
  input  logic [AddrWidth-1:0]   prog_counter,
  input  logic [AddrWidth-1:0]   ext_word,
  output iea_result_t            result
);

  logic [AddrWidth-1:0] idx_reg;
  logic [AddrWidth-1:0] base;
  logic [AddrWidth-1:0] offset;
  logic [AddrWidth-1:0] bias_ext;
  logic [AddrWidth-1:0] sum;

  always_comb begin
    unique case (ctrl.reg_sel)
      2'd0:    idx_reg = reg_x;
      2'd1:    idx_reg = reg_y;
      2'd2:    idx_reg = reg_u;
      default: idx_reg = reg_s;
    endcase
  end

  always_comb begin
    case (ctrl.base_sel)
      BASE_REG: base = idx_reg;
      BASE_PC:  base = prog_counter;
      default:  base = '0;
    endcase
  end

  always_comb begin
    case (ctrl.off_sel)
      OFF_SEXT5: offset = {{(AddrWidth-5){ctrl.off5[4]}}, ctrl.off5};
      OFF_ACC_B: offset = {{(AddrWidth-8){acc_d[7]}}, acc_d[7:0]};
      OFF_ACC_A: offset = {{(AddrWidth-8){acc_d[15]}}, acc_d[15:8]};
      OFF_EXT8:  offset = {{(AddrWidth-8){ext_word[15]}}, ext_word[15:8]};
      OFF_EXT16: offset = ext_word;
      OFF_ACC_D: offset = acc_d;
      default:   offset = '0;
    endcase
  end

  assign bias_ext = {{(AddrWidth-3){ctrl.bias[2]}}, ctrl.bias};
  assign sum      = base + offset + bias_ext;

  always_comb begin
    result = '0;
    if (ctrl.bad) begin
      result.pc_delta     = DeltaInvalid;
      result.invalid_post = 1'b1;
    end else begin
      result.ea_address     = ctrl.ea_base ? idx_reg : sum;
      result.needs_indirect = ctrl.ind;
      result.index_write    = ctrl.wr;
      result.index_select   = ctrl.wr ? ctrl.reg_sel : 2'd0;
      result.index_new      = ctrl.wr ? sum : '0;
      result.pc_delta       = ctrl.delta;
    end
  end

endmodule

@@ hdl/indexed_effective_address_unit.sv @@
// Indexed effective address unit: input register, decode and add, result register.
// The result register loads from the input stage; an output stall holds both stages.
// Throughput: one postbyte per cycle unless out_stall holds; 16-bit sum is combinational.
// Reset (rst, synchronous, active high) empties both stages; no other state is kept.
// Depends on iea_pkg, iea_decode and iea_addr.
module indexed_effective_address_unit
  import iea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           postbyte,
  input  logic [AddrWidth-1:0] reg_x,
  input  logic [AddrWidth-1:0] reg_y,
  input  logic [AddrWidth-1:0] reg_u,
  input  logic [AddrWidth-1:0] reg_s,
  input  logic [AddrWidth-1:0] acc_d,
  input  logic [AddrWidth-1:0] prog_counter,
  input  logic [AddrWidth-1:0] ext_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [AddrWidth-1:0] ea_address,
  output logic                 needs_indirect,
  output logic                 index_write,
  output logic [1:0]           index_select,
  output logic [AddrWidth-1:0] index_new,
  output logic signed [2:0]    pc_delta,
  output logic                 invalid_post
);

  logic                 s1_valid;
  logic [7:0]           s1_post;
  logic [AddrWidth-1:0] s1_x, s1_y, s1_u, s1_s, s1_d, s1_pc, s1_ext;
  logic                 out_free;
  logic                 s1_adv;
  iea_ctrl_t            ctrl;
  iea_result_t          result;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  // input stage frees up when its transfer moves on this cycle
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_post <= postbyte;
      s1_x    <= reg_x;
      s1_y    <= reg_y;
      s1_u    <= reg_u;
      s1_s    <= reg_s;
      s1_d    <= acc_d;
      s1_pc   <= prog_counter;
      s1_ext  <= ext_word;
    end
  end

  iea_decode u_decode (
    .postbyte (s1_post),
    .ctrl     (ctrl)
  );

  iea_addr u_addr (
    .ctrl         (ctrl),
    .reg_x        (s1_x),
    .reg_y        (s1_y),
    .reg_u        (s1_u),
    .reg_s        (s1_s),
    .acc_d        (s1_d),
    .prog_counter (s1_pc),
    .ext_word     (s1_ext),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ea_address     <= result.ea_address;
      needs_indirect <= result.needs_indirect;
      index_write    <= result.index_write;
      index_select   <= result.index_select;
      index_new      <= result.index_new;
      pc_delta       <= result.pc_delta;
      invalid_post   <= result.invalid_post;
    end
  end

  a_transfer_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted transfer not held in input stage");

  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid_post |->
      ea_address == '0 && !index_write && !needs_indirect && pc_delta == DeltaInvalid)
    else $error("invalid postbyte result not cleared");

  a_valid_delta: assert property (@(posedge clk) disable iff (rst)
    out_valid && !invalid_post |-> pc_delta != DeltaInvalid && pc_delta != 3'd3)
    else $error("pc change out of range on valid postbyte");

  a_step_direct: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_write |-> pc_delta == DeltaNone && !invalid_post)
    else $error("auto step with offset bytes or invalid flag");

endmodule
